/* rtl/synth_voice_allocator_assert.svh */
// Assertion macros shared by the voice allocator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sva_pkg.sv */
package sva_pkg;

    localparam int NUM_VOICES_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // A kill-all stops at most this many voices per event.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int LIMIT_W     = 5;
    localparam int KIND_W      = 2;
    localparam int PITCH_W     = 7;
    localparam int VEL_W       = 16;
    localparam int REQ_W       = 5;
    localparam int EV_TIME_W   = 32;
    localparam int VOICE_OUT_W = 4;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KILL_ALL = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VOICE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_STEAL = 1'b1;

    localparam logic [LIMIT_W-1:0] VOICE_LIMIT_RST = 5'd16;

    typedef struct packed {
        logic shift;
        logic set;
        logic clr;
    } cell_ctrl_t;

endpackage

/* rtl/sva_cell.sv */
module sva_cell #(
    parameter int TIME_BITS = sva_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sva_pkg::cell_ctrl_t          ctrl,
    input  logic                         in_active,
    input  logic [sva_pkg::PITCH_W-1:0]  in_pitch,
    input  logic [TIME_BITS-1:0]         in_start_time,
    input  logic [sva_pkg::PITCH_W-1:0]  wr_pitch,
    input  logic [TIME_BITS-1:0]         wr_start_time,
    output logic                         active,
    output logic [sva_pkg::PITCH_W-1:0]  pitch,
    output logic [TIME_BITS-1:0]         start_time
);

    logic                        active_reg;
    logic [sva_pkg::PITCH_W-1:0] pitch_reg;
    logic [TIME_BITS-1:0]        start_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            active_reg <= in_active;
        end
        else if (ctrl.set)
        begin
            active_reg <= 1'b1;
        end
        else if (ctrl.clr)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            pitch_reg      <= in_pitch;
            start_time_reg <= in_start_time;
        end
        else if (ctrl.set)
        begin
            pitch_reg      <= wr_pitch;
            start_time_reg <= wr_start_time;
        end
    end

    assign active     = active_reg;
    assign pitch      = pitch_reg;
    assign start_time = start_time_reg;

endmodule

/* rtl/sva_mod.sv */
module sva_mod #(
    parameter int W = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    num_reg;
    logic [W-1:0]    rem_reg;

    logic [W:0]      trial;
    logic [W:0]      diff;
    logic [W-1:0]    rem_step;

    // Restoring remainder, one dividend bit per cycle from the top.
    always_comb
    begin
        trial    = {rem_reg, num_reg[W-1]};
        diff     = trial - {1'b0, divisor};
        rem_step = (trial >= {1'b0, divisor}) ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/synth_voice_allocator.sv */
// Voice allocator: the voice state sits in a ring of NUM_VOICES cells that rotates one
// place per cycle past a single head while it scans, unless a kill-all stall holds it, so
// one event is examined voice by voice. A note-on with a requested voice goes straight to
// the decision; note-off and kill-all scan the ring first; a note-on that searches lets the
// remainder unit find the round-robin start, then scans and decides. One event at a time;
// results wait for the output, and a kill-all scan also waits while a held stop cannot leave.
// Reset (rst_n, asynchronous) frees all voices, sets voice_limit 16, stealing on, last voice 0.
`include "synth_voice_allocator_assert.svh"

module synth_voice_allocator #(
    parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF,
    parameter int TIME_BITS  = sva_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // event_time[31:0], note_pitch[38:32], velocity[54:39], requested_voice[59:55]
    input  logic [sva_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [sva_pkg::KIND_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // voice[3:0], out_pitch[10:4], out_time[42:11], out_velocity[58:43]
    output logic [sva_pkg::OUT_DATA_W-1:0]    m_tdata,
    // action[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [sva_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sva_pkg::LIMIT_W-1:0]       cfg_data
);

    localparam int VW = $clog2(NUM_VOICES);
    localparam int LW = VW + 1;
    localparam int CW = (LW > sva_pkg::LIMIT_W) ? LW : sva_pkg::LIMIT_W;
    localparam int TW = (TIME_BITS > sva_pkg::EV_TIME_W) ? TIME_BITS : sva_pkg::EV_TIME_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    // Control registers
    state_t                          state_reg, state_next;
    logic [sva_pkg::LIMIT_W-1:0]     limit_reg, limit_next;
    logic                            steal_reg, steal_next;
    logic [VW-1:0]                   last_voice_reg, last_voice_next;
    logic [VW-1:0]                   scan_idx_reg, scan_idx_next;
    logic                            hi_found_reg, hi_found_next;
    logic                            lo_found_reg, lo_found_next;
    logic                            best_found_reg, best_found_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [sva_pkg::CNT_W-1:0]       kill_cnt_reg, kill_cnt_next;
    logic                            out_valid_reg, out_valid_next;

    // Payload registers
    logic [sva_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [TIME_BITS-1:0]            ev_time_reg, ev_time_next;
    logic [sva_pkg::PITCH_W-1:0]     ev_pitch_reg, ev_pitch_next;
    logic [sva_pkg::VEL_W-1:0]       ev_vel_reg, ev_vel_next;
    logic                            req_ok_reg, req_ok_next;
    logic [VW-1:0]                   req_idx_reg, req_idx_next;
    logic [LW-1:0]                   start_reg, start_next;
    logic [VW-1:0]                   hi_idx_reg, hi_idx_next;
    logic [VW-1:0]                   lo_idx_reg, lo_idx_next;
    logic [VW-1:0]                   best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0]            best_time_reg, best_time_next;
    logic [VW-1:0]                   pend_idx_reg, pend_idx_next;
    logic [sva_pkg::PITCH_W-1:0]     pend_pitch_reg, pend_pitch_next;
    logic [TIME_BITS-1:0]            pend_time_reg, pend_time_next;
    logic                            out_action_reg, out_action_next;
    logic [sva_pkg::VOICE_OUT_W-1:0] out_voice_reg, out_voice_next;
    logic [sva_pkg::PITCH_W-1:0]     out_pitch_reg, out_pitch_next;
    logic [sva_pkg::EV_TIME_W-1:0]   out_time_reg, out_time_next;
    logic [sva_pkg::VEL_W-1:0]       out_vel_reg, out_vel_next;
    logic                            out_last_reg, out_last_next;

    // Input decode
    logic                            in_acc;
    logic [sva_pkg::KIND_W-1:0]      in_kind;
    logic [TW-1:0]                   in_time_wide;
    logic [sva_pkg::PITCH_W-1:0]     in_pitch;
    logic [sva_pkg::VEL_W-1:0]       in_vel;
    logic [sva_pkg::REQ_W-1:0]       in_req;
    logic                            in_req_ok;

    // Ring
    logic                            act_w [NUM_VOICES];
    logic [sva_pkg::PITCH_W-1:0]     pit_w [NUM_VOICES];
    logic [TIME_BITS-1:0]            tim_w [NUM_VOICES];
    sva_pkg::cell_ctrl_t             ctrl_w [NUM_VOICES];
    logic [NUM_VOICES-1:0]           cell_wr_vec;
    logic                            head_act;

    logic [CW-1:0]                   limit_wide;
    logic [LW-1:0]                   lim;
    logic [LW-1:0]                   scan_idx_w;
    logic                            in_lim;
    logic                            slot_free;
    logic                            kill_hit;
    logic                            scan_stall;
    logic                            step;
    logic                            out_load;

    logic                            on_go;
    logic [VW-1:0]                   on_v;
    logic                            dec_set;
    logic                            dec_clr;
    logic [VW-1:0]                   wr_idx;

    logic                            mod_start;
    logic                            mod_done;
    logic [LW-1:0]                   mod_rem;

    logic [TW-1:0]                   ev_time_wide;
    logic [TW-1:0]                   best_time_wide;
    logic [TW-1:0]                   pend_time_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign in_kind      = s_tuser;
    assign in_time_wide = TW'(s_tdata[31:0]);
    assign in_pitch     = s_tdata[38:32];
    assign in_vel       = s_tdata[54:39];
    assign in_req       = s_tdata[59:55];
    assign in_req_ok    = !in_req[sva_pkg::REQ_W-1]
                          && (CW'(in_req[sva_pkg::REQ_W-2:0]) < CW'(NUM_VOICES));

    // Effective voice limit: zero acts as one, anything above the voice count is clamped.
    always_comb
    begin
        limit_wide = CW'(limit_reg);
        if (limit_reg == '0)
        begin
            lim = LW'(1);
        end
        else if (limit_wide > CW'(NUM_VOICES))
        begin
            lim = LW'(NUM_VOICES);
        end
        else
        begin
            lim = LW'(limit_wide);
        end
    end

    assign scan_idx_w = LW'(scan_idx_reg);
    assign in_lim     = scan_idx_w < lim;
    assign slot_free  = !out_valid_reg || m_tready;

    assign kill_hit   = (kind_reg == sva_pkg::KIND_KILL_ALL) && act_w[0]
                        && (kill_cnt_reg < sva_pkg::CNT_W'(sva_pkg::MAX_RESULTS));
    // A second stop found while the previous one still cannot leave holds the ring.
    assign scan_stall = (state_reg == ST_SCAN) && kill_hit && pend_valid_reg && !slot_free;
    assign step       = (state_reg == ST_SCAN) && !scan_stall;
    assign head_act   = act_w[0] && !(step && kill_hit);

    // Note-on choice: requested voice, then free voice at or after the start point,
    // then free voice before it, then the oldest one if stealing is on.
    always_comb
    begin
        on_go = 1'b1;
        on_v  = best_idx_reg;
        if (req_ok_reg)
        begin
            on_v = req_idx_reg;
        end
        else if (hi_found_reg)
        begin
            on_v = hi_idx_reg;
        end
        else if (lo_found_reg)
        begin
            on_v = lo_idx_reg;
        end
        else if (!steal_reg)
        begin
            on_go = 1'b0;
        end
    end

    assign dec_set = (state_reg == ST_DECIDE) && (kind_reg == sva_pkg::KIND_NOTE_ON)
                     && on_go && slot_free;
    assign dec_clr = (state_reg == ST_DECIDE) && (kind_reg == sva_pkg::KIND_NOTE_OFF)
                     && best_found_reg && slot_free;
    assign wr_idx  = (kind_reg == sva_pkg::KIND_NOTE_ON) ? on_v : best_idx_reg;

    assign mod_start = in_acc && (in_kind == sva_pkg::KIND_NOTE_ON) && !in_req_ok;

    sva_mod #(
        .W (LW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (LW'(last_voice_reg) + LW'(1)),
        .divisor   (lim),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NUM_VOICES; gi++)
        begin : g_cell
            logic                        nxt_act;
            logic [sva_pkg::PITCH_W-1:0] nxt_pit;
            logic [TIME_BITS-1:0]        nxt_tim;

            if (gi == NUM_VOICES - 1)
            begin : g_tail
                assign nxt_act = head_act;
                assign nxt_pit = pit_w[0];
                assign nxt_tim = tim_w[0];
            end
            else
            begin : g_body
                assign nxt_act = act_w[gi + 1];
                assign nxt_pit = pit_w[gi + 1];
                assign nxt_tim = tim_w[gi + 1];
            end

            assign ctrl_w[gi] = '{
                shift: step,
                set:   dec_set && (wr_idx == VW'(gi)),
                clr:   dec_clr && (wr_idx == VW'(gi))
            };
            assign cell_wr_vec[gi] = ctrl_w[gi].set | ctrl_w[gi].clr;

            sva_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl_w[gi]),
                .in_active     (nxt_act),
                .in_pitch      (nxt_pit),
                .in_start_time (nxt_tim),
                .wr_pitch      (ev_pitch_reg),
                .wr_start_time (ev_time_reg),
                .active        (act_w[gi]),
                .pitch         (pit_w[gi]),
                .start_time    (tim_w[gi])
            );
        end
    endgenerate

    assign ev_time_wide   = TW'(ev_time_reg);
    assign best_time_wide = TW'(best_time_reg);
    assign pend_time_wide = TW'(pend_time_reg);

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        steal_next      = steal_reg;
        last_voice_next = last_voice_reg;
        scan_idx_next   = scan_idx_reg;
        hi_found_next   = hi_found_reg;
        lo_found_next   = lo_found_reg;
        best_found_next = best_found_reg;
        pend_valid_next = pend_valid_reg;
        kill_cnt_next   = kill_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        kind_next       = kind_reg;
        ev_time_next    = ev_time_reg;
        ev_pitch_next   = ev_pitch_reg;
        ev_vel_next     = ev_vel_reg;
        req_ok_next     = req_ok_reg;
        req_idx_next    = req_idx_reg;
        start_next      = start_reg;
        hi_idx_next     = hi_idx_reg;
        lo_idx_next     = lo_idx_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        pend_idx_next   = pend_idx_reg;
        pend_pitch_next = pend_pitch_reg;
        pend_time_next  = pend_time_reg;
        out_action_next = out_action_reg;
        out_voice_next  = out_voice_reg;
        out_pitch_next  = out_pitch_reg;
        out_time_next   = out_time_reg;
        out_vel_next    = out_vel_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                sva_pkg::REG_VOICE_LIMIT: limit_next = cfg_data;
                sva_pkg::REG_ALLOW_STEAL: steal_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next       = in_kind;
                    ev_time_next    = in_time_wide[TIME_BITS-1:0];
                    ev_pitch_next   = in_pitch;
                    ev_vel_next     = in_vel;
                    req_ok_next     = in_req_ok;
                    req_idx_next    = VW'(in_req[sva_pkg::REQ_W-2:0]);
                    scan_idx_next   = '0;
                    hi_found_next   = 1'b0;
                    lo_found_next   = 1'b0;
                    best_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    kill_cnt_next   = '0;
                    case (in_kind)
                        sva_pkg::KIND_NOTE_ON:
                        begin
                            state_next = in_req_ok ? ST_DECIDE : ST_MOD;
                        end
                        sva_pkg::KIND_NOTE_OFF,
                        sva_pkg::KIND_KILL_ALL:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    start_next = mod_rem;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (step)
                begin
                    case (kind_reg)
                        sva_pkg::KIND_NOTE_ON:
                        begin
                            if (in_lim && !act_w[0])
                            begin
                                if (scan_idx_w >= start_reg)
                                begin
                                    if (!hi_found_reg)
                                    begin
                                        hi_found_next = 1'b1;
                                        hi_idx_next   = scan_idx_reg;
                                    end
                                end
                                else if (!lo_found_reg)
                                begin
                                    lo_found_next = 1'b1;
                                    lo_idx_next   = scan_idx_reg;
                                end
                            end
                            if (in_lim && (!best_found_reg || (tim_w[0] < best_time_reg)))
                            begin
                                best_found_next = 1'b1;
                                best_idx_next   = scan_idx_reg;
                                best_time_next  = tim_w[0];
                            end
                        end
                        sva_pkg::KIND_NOTE_OFF:
                        begin
                            if (req_ok_reg)
                            begin
                                if ((scan_idx_reg == req_idx_reg) && act_w[0]
                                    && (pit_w[0] == ev_pitch_reg))
                                begin
                                    best_found_next = 1'b1;
                                    best_idx_next   = scan_idx_reg;
                                    best_time_next  = tim_w[0];
                                end
                            end
                            else if (in_lim && act_w[0] && (pit_w[0] == ev_pitch_reg)
                                     && (!best_found_reg || (tim_w[0] < best_time_reg)))
                            begin
                                best_found_next = 1'b1;
                                best_idx_next   = scan_idx_reg;
                                best_time_next  = tim_w[0];
                            end
                        end
                        sva_pkg::KIND_KILL_ALL:
                        begin
                            // The latest stop is held back until we know whether it is final.
                            if (kill_hit)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_load        = 1'b1;
                                    out_action_next = sva_pkg::ACT_STOP;
                                    out_voice_next  = sva_pkg::VOICE_OUT_W'(pend_idx_reg);
                                    out_pitch_next  = pend_pitch_reg;
                                    out_time_next   = pend_time_wide[sva_pkg::EV_TIME_W-1:0];
                                    out_vel_next    = '0;
                                    out_last_next   = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_idx_next   = scan_idx_reg;
                                pend_pitch_next = pit_w[0];
                                pend_time_next  = tim_w[0];
                                kill_cnt_next   = kill_cnt_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (scan_idx_reg == VW'(NUM_VOICES - 1))
                    begin
                        scan_idx_next = '0;
                        state_next    = ST_DECIDE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            ST_DECIDE:
            begin
                case (kind_reg)
                    sva_pkg::KIND_NOTE_ON:
                    begin
                        if (!on_go)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (slot_free)
                        begin
                            out_load        = 1'b1;
                            out_action_next = sva_pkg::ACT_START;
                            out_voice_next  = sva_pkg::VOICE_OUT_W'(on_v);
                            out_pitch_next  = ev_pitch_reg;
                            out_time_next   = ev_time_wide[sva_pkg::EV_TIME_W-1:0];
                            out_vel_next    = ev_vel_reg;
                            out_last_next   = 1'b1;
                            last_voice_next = on_v;
                            state_next      = ST_IDLE;
                        end
                    end
                    sva_pkg::KIND_NOTE_OFF:
                    begin
                        if (!best_found_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (slot_free)
                        begin
                            out_load        = 1'b1;
                            out_action_next = sva_pkg::ACT_STOP;
                            out_voice_next  = sva_pkg::VOICE_OUT_W'(best_idx_reg);
                            out_pitch_next  = ev_pitch_reg;
                            out_time_next   = best_time_wide[sva_pkg::EV_TIME_W-1:0];
                            out_vel_next    = '0;
                            out_last_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    sva_pkg::KIND_KILL_ALL:
                    begin
                        if (!pend_valid_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (slot_free)
                        begin
                            out_load        = 1'b1;
                            out_action_next = sva_pkg::ACT_STOP;
                            out_voice_next  = sva_pkg::VOICE_OUT_W'(pend_idx_reg);
                            out_pitch_next  = pend_pitch_reg;
                            out_time_next   = pend_time_wide[sva_pkg::EV_TIME_W-1:0];
                            out_vel_next    = '0;
                            out_last_next   = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= sva_pkg::VOICE_LIMIT_RST;
            steal_reg      <= 1'b1;
            last_voice_reg <= '0;
            scan_idx_reg   <= '0;
            hi_found_reg   <= 1'b0;
            lo_found_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            kill_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            steal_reg      <= steal_next;
            last_voice_reg <= last_voice_next;
            scan_idx_reg   <= scan_idx_next;
            hi_found_reg   <= hi_found_next;
            lo_found_reg   <= lo_found_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            kill_cnt_reg   <= kill_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ev_time_reg    <= ev_time_next;
        ev_pitch_reg   <= ev_pitch_next;
        ev_vel_reg     <= ev_vel_next;
        req_ok_reg     <= req_ok_next;
        req_idx_reg    <= req_idx_next;
        start_reg      <= start_next;
        hi_idx_reg     <= hi_idx_next;
        lo_idx_reg     <= lo_idx_next;
        best_idx_reg   <= best_idx_next;
        best_time_reg  <= best_time_next;
        pend_idx_reg   <= pend_idx_next;
        pend_pitch_reg <= pend_pitch_next;
        pend_time_reg  <= pend_time_next;
        out_action_reg <= out_action_next;
        out_voice_reg  <= out_voice_next;
        out_pitch_reg  <= out_pitch_next;
        out_time_reg   <= out_time_next;
        out_vel_reg    <= out_vel_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sva_pkg::OUT_DATA_W'({out_vel_reg, out_time_reg, out_pitch_reg,
                                             out_voice_reg});
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;

    // Between events the ring must be back in line, voice k in cell k.
    `SVA_ASSERT_NOW(a_ring_aligned_idle, state_reg == ST_IDLE, scan_idx_reg == '0,
                    "ring not aligned while idle")
    // At most one cell is written per cycle, and never while the ring rotates.
    `SVA_ASSERT_NOW(a_single_cell_write, state_reg == ST_SCAN || state_reg != ST_SCAN,
                    $onehot0(cell_wr_vec) && !(step && (cell_wr_vec != '0)),
                    "cell write collides with rotation or another write")
    // A beat is only loaded into the output register once the previous one has gone.
    `SVA_ASSERT_NOW(a_no_overwrite, out_load, slot_free,
                    "output beat overwritten before it was taken")

endmodule

/* tb/sv/synth_voice_allocator_tb.sv */
module synth_voice_allocator_tb;

    import sva_pkg::*;

    localparam int NV          = NUM_VOICES_DEF;
    localparam int SETTLE      = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES      = 8;
    localparam int PER_PHASE   = 65;

    // The one kind that the block ignores, and the raw code for "block chooses".
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [REQ_W-1:0]  REQ_ANY     = 5'h1F;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [EV_TIME_W-1:0] t;
        logic [PITCH_W-1:0]   pitch;
        logic [VEL_W-1:0]     vel;
        logic [REQ_W-1:0]     req;
    } note_event_t;

    typedef struct {
        logic                   action;
        logic [VOICE_OUT_W-1:0] voice;
        logic [PITCH_W-1:0]     pitch;
        logic [EV_TIME_W-1:0]   t;
        logic [VEL_W-1:0]       vel;
        logic                   last;
    } voice_cmd_t;

    class voice_tracker;
        voice_cmd_t           voice_cmd_q[$];
        bit                   active[NV];
        logic [PITCH_W-1:0]   held_pitch[NV];
        logic [EV_TIME_W-1:0] start_time[NV];
        int                   last_voice;
        logic [LIMIT_W-1:0]   limit;
        bit                   steal;
        int                   errors;
        int                   checked;
        int                   starts;
        int                   stops;

        function new();
            for (int i = 0; i < NV; i++)
            begin
                active[i]     = 1'b0;
                held_pitch[i] = '0;
                start_time[i] = '0;
            end
            last_voice = 0;
            limit      = VOICE_LIMIT_RST;
            steal      = 1'b1;
            errors     = 0;
            checked    = 0;
            starts     = 0;
            stops      = 0;
        endfunction

        function void set_config(logic [LIMIT_W-1:0] lim_val, bit steal_val);
            limit = lim_val;
            steal = steal_val;
        endfunction

        function int pending();
            return voice_cmd_q.size();
        endfunction

        // Returns a random voice that is sounding, or -1 when all are free.
        function int random_active_voice();
            int busy[$];
            for (int i = 0; i < NV; i++)
                if (active[i])
                    busy.push_back(i);
            if (busy.size() == 0)
                return -1;
            return busy[$urandom_range(busy.size() - 1)];
        endfunction

        function void note_event(note_event_t ev);
            int         lim;
            int         v;
            int         c;
            int         n;
            bit         found;
            logic [EV_TIME_W-1:0] oldest;
            voice_cmd_t cmd;
            // Any value with the sign bit set asks the block to choose.
            v   = ev.req[REQ_W-1] ? -1 : int'(ev.req);
            lim = (limit == 0) ? 1 : ((limit > NV) ? NV : int'(limit));
            case (ev.kind)
                KIND_NOTE_ON:
                begin
                    for (int i = 0; i < lim && v < 0; i++)
                    begin
                        c = (i + last_voice + 1) % lim;
                        if (!active[c])
                            v = c;
                    end
                    if (v < 0)
                    begin
                        if (!steal)
                            return;
                        v = 0;
                        for (int i = 1; i < lim; i++)
                            if (start_time[i] < start_time[v])
                                v = i;
                    end
                    last_voice    = v;
                    active[v]     = 1'b1;
                    held_pitch[v] = ev.pitch;
                    start_time[v] = ev.t;
                    cmd.action = ACT_START;
                    cmd.voice  = v[VOICE_OUT_W-1:0];
                    cmd.pitch  = ev.pitch;
                    cmd.t      = ev.t;
                    cmd.vel    = ev.vel;
                    cmd.last   = 1'b1;
                    voice_cmd_q.push_back(cmd);
                end
                KIND_NOTE_OFF:
                begin
                    if (v < 0)
                    begin
                        found  = 1'b0;
                        oldest = '0;
                        for (int i = 0; i < lim; i++)
                            if (active[i] && held_pitch[i] == ev.pitch &&
                                (!found || start_time[i] < oldest))
                            begin
                                found  = 1'b1;
                                oldest = start_time[i];
                                v      = i;
                            end
                    end
                    if (v >= 0 && active[v] && held_pitch[v] == ev.pitch)
                    begin
                        active[v]  = 1'b0;
                        cmd.action = ACT_STOP;
                        cmd.voice  = v[VOICE_OUT_W-1:0];
                        cmd.pitch  = held_pitch[v];
                        cmd.t      = start_time[v];
                        cmd.vel    = '0;
                        cmd.last   = 1'b1;
                        voice_cmd_q.push_back(cmd);
                    end
                end
                KIND_KILL_ALL:
                begin
                    // Each stop is held back one step so the final one can carry last.
                    n = 0;
                    for (int i = 0; i < NV && n < MAX_RESULTS; i++)
                        if (active[i])
                        begin
                            if (n > 0)
                                voice_cmd_q.push_back(cmd);
                            active[i]  = 1'b0;
                            cmd.action = ACT_STOP;
                            cmd.voice  = i[VOICE_OUT_W-1:0];
                            cmd.pitch  = held_pitch[i];
                            cmd.t      = start_time[i];
                            cmd.vel    = '0;
                            cmd.last   = 1'b0;
                            n++;
                        end
                    if (n > 0)
                    begin
                        cmd.last = 1'b1;
                        voice_cmd_q.push_back(cmd);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_command(voice_cmd_t got);
            voice_cmd_t want;
            if (voice_cmd_q.size() == 0)
            begin
                errors++;
                $error("unexpected result beat: action %0d voice %0d", got.action, got.voice);
                return;
            end
            want = voice_cmd_q.pop_front();
            checked++;
            if (want.action == ACT_START)
                starts++;
            else
                stops++;
            if (got.action !== want.action)
            begin
                errors++;
                $error("action mismatch: expected %0d, actual %0d", want.action, got.action);
            end
            if (got.voice !== want.voice)
            begin
                errors++;
                $error("voice mismatch: expected %0d, actual %0d", want.voice, got.voice);
            end
            if (got.pitch !== want.pitch)
            begin
                errors++;
                $error("out_pitch mismatch: expected %0d, actual %0d", want.pitch, got.pitch);
            end
            if (got.t !== want.t)
            begin
                errors++;
                $error("out_time mismatch: expected %0h, actual %0h", want.t, got.t);
            end
            if (got.vel !== want.vel)
            begin
                errors++;
                $error("out_velocity mismatch: expected %0h, actual %0h", want.vel, got.vel);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [LIMIT_W-1:0]    cfg_data;

    voice_tracker         tracker;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   cycles;
    int                   settings_used;
    int                   n_on;
    int                   n_off;
    int                   n_kill;
    int                   n_ignored;
    logic [EV_TIME_W-1:0] ticks;

    synth_voice_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, tracker.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: stall at random, check every beat that is taken.
    initial
    begin
        voice_cmd_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.action = m_tuser[0];
                got.voice  = m_tdata[3:0];
                got.pitch  = m_tdata[10:4];
                got.t      = m_tdata[42:11];
                got.vel    = m_tdata[58:43];
                got.last   = m_tlast;
                tracker.check_command(got);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_event(note_event_t ev);
        s_tvalid <= 1'b1;
        s_tuser  <= ev.kind;
        s_tdata  <= {4'b0, ev.req, ev.vel, ev.pitch, ev.t};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_event(ev);
        case (ev.kind)
            KIND_NOTE_ON:  n_on++;
            KIND_NOTE_OFF: n_off++;
            KIND_KILL_ALL: n_kill++;
            default:       n_ignored++;
        endcase
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send(logic [KIND_W-1:0] kind, logic [EV_TIME_W-1:0] t,
                        logic [PITCH_W-1:0] pitch, logic [VEL_W-1:0] vel,
                        logic [REQ_W-1:0] req);
        note_event_t ev;
        ev.kind  = kind;
        ev.t     = t;
        ev.pitch = pitch;
        ev.vel   = vel;
        ev.req   = req;
        send_event(ev);
    endtask

    // Hold the input off until every expected result is out, then let the
    // block finish any event that gives no result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(logic [LIMIT_W-1:0] lim_val, bit steal_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VOICE_LIMIT;
        cfg_data  <= lim_val;
        @(posedge clk);
        cfg_index <= REG_ALLOW_STEAL;
        cfg_data  <= {{(LIMIT_W-1){1'b0}}, steal_val};
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_config(lim_val, steal_val);
        settings_used++;
    endtask

    function automatic logic [REQ_W-1:0] random_request();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return REQ_ANY;
        if (r < 85)
            return $urandom_range(NV - 1);
        return $urandom_range(31);
    endfunction

    task automatic make_random_event(output note_event_t ev);
        int r;
        int v;
        if ($urandom_range(9) == 0)
            ticks = $urandom();
        else
            ticks = ticks + $urandom_range(40);
        ev.t     = ticks;
        ev.vel   = $urandom();
        ev.pitch = ($urandom_range(3) == 0) ? $urandom_range(127) : 60 + $urandom_range(7);
        ev.req   = random_request();
        r = $urandom_range(99);
        if (r < 48)
            ev.kind = KIND_NOTE_ON;
        else if (r < 85)
        begin
            ev.kind = KIND_NOTE_OFF;
            v = tracker.random_active_voice();
            // Mostly release a note that is really sounding.
            if (v >= 0 && $urandom_range(9) < 8)
            begin
                ev.pitch = tracker.held_pitch[v];
                ev.req   = ($urandom_range(2) == 0) ? v[REQ_W-1:0] : REQ_ANY;
            end
        end
        else if (r < 93)
            ev.kind = KIND_KILL_ALL;
        else
            ev.kind = KIND_UNUSED;
    endtask

    initial
    begin
        note_event_t        ev;
        int                 sent;
        logic [LIMIT_W-1:0] limits[PHASES];
        bit                 steals[PHASES];
        limits = '{5'd16, 5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd6, 5'd12};
        steals = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        tracker        = new();
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= KIND_NOTE_ON;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_VOICE_LIMIT;
        cfg_data      <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_used  = 1;
        n_on           = 0;
        n_off          = 0;
        n_kill         = 0;
        n_ignored      = 0;
        ticks          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset settings.
        send(KIND_NOTE_ON,  32'h0,        7'd0,   16'h0,    REQ_ANY);
        send(KIND_NOTE_ON,  32'hFFFFFFFF, 7'd127, 16'hFFFF, REQ_ANY);
        send(KIND_NOTE_ON,  32'd100,      7'd60,  16'h1234, 5'd5);
        send(KIND_NOTE_ON,  32'd200,      7'd61,  16'h0005, 5'd5);
        send(KIND_NOTE_ON,  32'd300,      7'd62,  16'hA5A5, 5'h10);
        send(KIND_NOTE_OFF, 32'd310,      7'd60,  16'h0,    5'd5);
        send(KIND_NOTE_OFF, 32'd320,      7'd61,  16'h0,    5'd5);
        send(KIND_NOTE_OFF, 32'd330,      7'd127, 16'hFFFF, REQ_ANY);
        send(KIND_NOTE_OFF, 32'd340,      7'd99,  16'h0,    5'h15);
        send(KIND_UNUSED,   32'hFFFFFFFF, 7'd127, 16'hFFFF, 5'd15);
        send(KIND_NOTE_ON,  32'd300,      7'd62,  16'h5A5A, REQ_ANY);
        send(KIND_NOTE_OFF, 32'd350,      7'd62,  16'h0,    REQ_ANY);
        send(KIND_KILL_ALL, 32'd360,      7'd0,   16'h0,    REQ_ANY);
        send(KIND_KILL_ALL, 32'd370,      7'd0,   16'h0,    REQ_ANY);
        drain();
        // Two voices and no stealing: the third note is dropped.
        write_config(5'd2, 1'b0);
        send(KIND_NOTE_ON,  32'd500,      7'd10,  16'h0100, REQ_ANY);
        send(KIND_NOTE_ON,  32'd400,      7'd11,  16'h0200, REQ_ANY);
        send(KIND_NOTE_ON,  32'd450,      7'd12,  16'h0300, REQ_ANY);
        send(KIND_NOTE_ON,  32'd600,      7'd13,  16'h0400, 5'd9);
        drain();
        write_config(5'd2, 1'b1);
        send(KIND_NOTE_ON,  32'd700,      7'd14,  16'h0500, REQ_ANY);
        send(KIND_NOTE_OFF, 32'd710,      7'd13,  16'h0,    REQ_ANY);
        send(KIND_NOTE_OFF, 32'd720,      7'd13,  16'h0,    5'd9);
        drain();
        // A limit of zero behaves as one voice.
        write_config(5'd0, 1'b1);
        send(KIND_NOTE_ON,  32'd800,      7'd20,  16'h0600, REQ_ANY);
        send(KIND_NOTE_ON,  32'd810,      7'd21,  16'hFFFF, 5'd15);
        drain();
        write_config(5'd31, 1'b0);
        send(KIND_KILL_ALL, 32'd900,      7'd0,   16'h0,    REQ_ANY);
        drain();

        // Random phases, each with its own voice settings and idling pattern.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_config(limits[phase], steals[phase]);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            sent = 0;
            while (sent < PER_PHASE)
            begin
                make_random_event(ev);
                send_event(ev);
                if (ev.kind != KIND_UNUSED)
                    sent++;
                if (sent == PER_PHASE / 2 && ev.kind != KIND_UNUSED)
                    drain();
            end
            drain();
        end

        if (tracker.pending() != 0)
        begin
            tracker.errors++;
            $error("%0d expected results never arrived", tracker.pending());
        end
        $display("Ran %0d note-on, %0d note-off, %0d kill-all and %0d ignored events",
                 n_on, n_off, n_kill, n_ignored);
        $display("over %0d voice settings; %0d results checked (%0d starts, %0d stops)",
                 settings_used, tracker.checked, tracker.starts, tracker.stops);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
